// ----- hdl/median_mad_outlier_filter_3x3_macros.svh -----
// ----------------------------------------------------------------------------
// median_mad_outlier_filter_3x3 assertion macros
// shared concurrent assertion forms, clocked on clock, quiet under reset
// ----------------------------------------------------------------------------
`ifndef MEDIAN_MAD_OUTLIER_FILTER_3X3_MACROS_SVH
`define MEDIAN_MAD_OUTLIER_FILTER_3X3_MACROS_SVH

// same-cycle implication
`define MMOF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MMOF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mmof_pkg.sv -----
// ----------------------------------------------------------------------------
// mmof_pkg
// types and constants shared by the 3x3 median / mad outlier filter
// ----------------------------------------------------------------------------
package mmof_pkg;

   // configuration registers
   localparam int REG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DARK_THRESHOLD = 1'b0,
      CSR_OUTLIER_GAIN   = 1'b1
   } csr_index_type;

   localparam logic [REG_BITS-1:0] DARK_THRESHOLD_RESET = 16'd0;
   localparam logic [REG_BITS-1:0] OUTLIER_GAIN_RESET   = 16'd1138;

   // result decision codes
   typedef enum logic [1:0] {
      DEC_KEEP    = 2'd0,
      DEC_DARK    = 2'd1,
      DEC_OUTLIER = 2'd2
   } decision_type;

   // stage enables of one median network
   typedef struct packed {
      logic rows;
      logic tri3;
      logic med;
   } med_en_type;

   // pipeline depth of the whole filter
   localparam int NUM_STAGES = 10;

endpackage

// ----- hdl/median_mad_outlier_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_mad_outlier_filter_3x3
// 3x3 median filter that replaces dark or outlying centre pixels
// ----------------------------------------------------------------------------
// Takes one 3x3 window per beat and returns one filtered centre pixel per
// beat. Throughput is one window per clock while rsp_ready is held high;
// each accepted beat passes through ten register stages: an input register,
// two three-stage median networks (window median, then median of the absolute
// deviations), a deviation stage, a multiply stage and the result register.
// Each stage moves on when the one after it is empty or moving, so bubbles
// close up and a waiting result does not stop new beats while space is left.
// csr registers may only be written while no beat is in flight.
// ----------------------------------------------------------------------------
module median_mad_outlier_filter_3x3 #(
   parameter int PIXEL_BITS     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  mmof_pkg::csr_index_type               csr_index,
   input  logic [mmof_pkg::REG_BITS-1:0]         csr_write_data,
   // request
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [PIXEL_BITS-1:0]                 req_sample_up_left,
   input  logic [PIXEL_BITS-1:0]                 req_sample_up,
   input  logic [PIXEL_BITS-1:0]                 req_sample_up_right,
   input  logic [PIXEL_BITS-1:0]                 req_sample_left,
   input  logic [PIXEL_BITS-1:0]                 req_center_sample,
   input  logic [PIXEL_BITS-1:0]                 req_sample_right,
   input  logic [PIXEL_BITS-1:0]                 req_sample_down_left,
   input  logic [PIXEL_BITS-1:0]                 req_sample_down,
   input  logic [PIXEL_BITS-1:0]                 req_sample_down_right,
   // response
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [PIXEL_BITS-1:0]                 rsp_filtered_pixel,
   output mmof_pkg::decision_type                rsp_decision
);
   import mmof_pkg::*;
   `include "median_mad_outlier_filter_3x3_macros.svh"

   localparam int CMP_BITS  = (PIXEL_BITS > REG_BITS) ? PIXEL_BITS : REG_BITS;
   localparam int PROD_BITS = REG_BITS + PIXEL_BITS;
   localparam int SIDE_BITS = 3 * PIXEL_BITS + 1;
   localparam int LAST      = NUM_STAGES - 1;

   // side vector fields: {dark, diff, med, centre}
   localparam int CEN_LO  = 0;
   localparam int MED_LO  = PIXEL_BITS;
   localparam int DIFF_LO = 2 * PIXEL_BITS;
   localparam int DARK_AT = 3 * PIXEL_BITS;

   logic [REG_BITS-1:0]   dark_threshold_ff;
   logic [REG_BITS-1:0]   outlier_gain_ff;

   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] en;

   logic [PIXEL_BITS-1:0] w0_ff [9];
   logic [PIXEL_BITS-1:0] w1_ff [9];
   logic [PIXEL_BITS-1:0] w2_ff [9];
   logic [PIXEL_BITS-1:0] w3_ff [9];
   logic [PIXEL_BITS-1:0] med3_out;

   logic [PIXEL_BITS-1:0] dev_in [9];
   logic [PIXEL_BITS-1:0] dev4_ff [9];
   logic [SIDE_BITS-1:0]  side4_in;
   logic [SIDE_BITS-1:0]  side4_ff, side5_ff, side6_ff, side7_ff, side8_ff;
   logic [PIXEL_BITS-1:0] mad7_out;

   logic [PROD_BITS-1:0]  prod8_in, prod8_ff;
   logic [PROD_BITS-1:0]  scaled8_in, scaled8_ff;

   logic [PIXEL_BITS-1:0] pix9_in, pix9_ff;
   decision_type          dec9_in, dec9_ff;

   med_en_type            med_a_en, med_b_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff <= DARK_THRESHOLD_RESET;
         outlier_gain_ff   <= OUTLIER_GAIN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_write_data;
            CSR_OUTLIER_GAIN:   outlier_gain_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage load enables: a stage loads when empty or when its successor loads
   always_comb begin
      en[LAST] = !v_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_ready = en[0];

   // input register
   always_ff @(posedge clock) begin
      if (en[0]) begin
         w0_ff[0] <= req_sample_up_left;
         w0_ff[1] <= req_sample_up;
         w0_ff[2] <= req_sample_up_right;
         w0_ff[3] <= req_sample_left;
         w0_ff[4] <= req_center_sample;
         w0_ff[5] <= req_sample_right;
         w0_ff[6] <= req_sample_down_left;
         w0_ff[7] <= req_sample_down;
         w0_ff[8] <= req_sample_down_right;
      end
   end

   // window median, stages 1 to 3
   assign med_a_en = '{rows: en[1], tri3: en[2], med: en[3]};

   mmof_median9 #(
      .DATA_BITS (PIXEL_BITS)
   ) u_med_window (
      .clock     (clock),
      .en        (med_a_en),
      .sample_in (w0_ff),
      .med_out   (med3_out)
   );

   // window travels alongside the median network
   always_ff @(posedge clock) begin
      if (en[1]) w1_ff <= w0_ff;
      if (en[2]) w2_ff <= w1_ff;
      if (en[3]) w3_ff <= w2_ff;
   end

   // absolute deviations, centre distance and dark test
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         dev_in[i] = (w3_ff[i] > med3_out) ? (w3_ff[i] - med3_out)
                                          : (med3_out - w3_ff[i]);
      end
      side4_in[CEN_LO +: PIXEL_BITS]  = w3_ff[4];
      side4_in[MED_LO +: PIXEL_BITS]  = med3_out;
      side4_in[DIFF_LO +: PIXEL_BITS] = dev_in[4];
      side4_in[DARK_AT] = CMP_BITS'(w3_ff[4]) < CMP_BITS'(dark_threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         dev4_ff  <= dev_in;
         side4_ff <= side4_in;
      end
   end

   // median of the deviations, stages 5 to 7
   assign med_b_en = '{rows: en[5], tri3: en[6], med: en[7]};

   mmof_median9 #(
      .DATA_BITS (PIXEL_BITS)
   ) u_med_dev (
      .clock     (clock),
      .en        (med_b_en),
      .sample_in (dev4_ff),
      .med_out   (mad7_out)
   );

   always_ff @(posedge clock) begin
      if (en[5]) side5_ff <= side4_ff;
      if (en[6]) side6_ff <= side5_ff;
      if (en[7]) side7_ff <= side6_ff;
   end

   // gain times mad against scaled centre distance
   assign prod8_in   = PROD_BITS'(outlier_gain_ff) * PROD_BITS'(mad7_out);
   assign scaled8_in = PROD_BITS'(side7_ff[DIFF_LO +: PIXEL_BITS]) << GAIN_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         prod8_ff   <= prod8_in;
         scaled8_ff <= scaled8_in;
         side8_ff   <= side7_ff;
      end
   end

   // final choice: dark first, then outlier, else keep
   always_comb begin
      priority if (side8_ff[DARK_AT]) begin
         pix9_in = side8_ff[MED_LO +: PIXEL_BITS];
         dec9_in = DEC_DARK;
      end else if (scaled8_ff > prod8_ff) begin
         pix9_in = side8_ff[MED_LO +: PIXEL_BITS];
         dec9_in = DEC_OUTLIER;
      end else begin
         pix9_in = side8_ff[CEN_LO +: PIXEL_BITS];
         dec9_in = DEC_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         pix9_ff <= pix9_in;
         dec9_ff <= dec9_in;
      end
   end

   assign rsp_valid          = v_ff[LAST];
   assign rsp_filtered_pixel = pix9_ff;
   assign rsp_decision       = dec9_ff;

   // checks
   `MMOF_ASSERT_IMP(a_full_stall_blocks, (&v_ff) && !rsp_ready, !req_ready, "accept while full and stalled")
   `MMOF_ASSERT_NEXT(a_full_stays_full, (&v_ff) && !rsp_ready, (&v_ff), "beat lost during stall")
   `MMOF_ASSERT_IMP(a_occupancy, !$past(reset), $countones(v_ff) + $past(rsp_valid && rsp_ready) == $past($countones(v_ff)) + $past(req_valid && req_ready), "pipeline occupancy mismatch")
   `MMOF_ASSERT_IMP(a_dark_needs_threshold, rsp_valid && rsp_decision == DEC_DARK, dark_threshold_ff != '0, "dark decision with test disabled")

endmodule

// ----- hdl/mmof_median9.sv -----
// ----------------------------------------------------------------------------
// mmof_median9
// three-stage median of nine: row sort, max/median/min across rows,
// median of three
// ----------------------------------------------------------------------------
module mmof_median9 #(
   parameter int DATA_BITS = 16
) (
   input  logic                      clock,
   input  mmof_pkg::med_en_type      en,
   input  logic [DATA_BITS-1:0]      sample_in [9],
   output logic [DATA_BITS-1:0]      med_out
);
   import mmof_pkg::*;

   function automatic logic [DATA_BITS-1:0] min_of(input logic [DATA_BITS-1:0] a,
                                                    input logic [DATA_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [DATA_BITS-1:0] max_of(input logic [DATA_BITS-1:0] a,
                                                    input logic [DATA_BITS-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [DATA_BITS-1:0] med3(input logic [DATA_BITS-1:0] a,
                                                  input logic [DATA_BITS-1:0] b,
                                                  input logic [DATA_BITS-1:0] c);
      return max_of(min_of(a, b), min_of(max_of(a, b), c));
   endfunction

   logic [DATA_BITS-1:0] row_min_in [3];
   logic [DATA_BITS-1:0] row_mid_in [3];
   logic [DATA_BITS-1:0] row_max_in [3];
   logic [DATA_BITS-1:0] row_min_ff [3];
   logic [DATA_BITS-1:0] row_mid_ff [3];
   logic [DATA_BITS-1:0] row_max_ff [3];
   logic [DATA_BITS-1:0] lo_in, mid_in, hi_in;
   logic [DATA_BITS-1:0] lo_ff, mid_ff, hi_ff;
   logic [DATA_BITS-1:0] med_in, med_ff;

   // sort each row of three
   always_comb begin
      logic [DATA_BITS-1:0] lo1, hi1, t;
      for (int r = 0; r < 3; r++) begin
         lo1 = min_of(sample_in[3*r], sample_in[3*r+1]);
         hi1 = max_of(sample_in[3*r], sample_in[3*r+1]);
         t   = min_of(hi1, sample_in[3*r+2]);
         row_max_in[r] = max_of(hi1, sample_in[3*r+2]);
         row_min_in[r] = min_of(lo1, t);
         row_mid_in[r] = max_of(lo1, t);
      end
   end

   always_ff @(posedge clock) begin
      if (en.rows) begin
         row_min_ff <= row_min_in;
         row_mid_ff <= row_mid_in;
         row_max_ff <= row_max_in;
      end
   end

   // largest minimum, median of medians, smallest maximum
   always_comb begin
      lo_in  = max_of(max_of(row_min_ff[0], row_min_ff[1]), row_min_ff[2]);
      mid_in = med3(row_mid_ff[0], row_mid_ff[1], row_mid_ff[2]);
      hi_in  = min_of(min_of(row_max_ff[0], row_max_ff[1]), row_max_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en.tri3) begin
         lo_ff  <= lo_in;
         mid_ff <= mid_in;
         hi_ff  <= hi_in;
      end
   end

   // the median of the three candidates is the window median
   assign med_in = med3(lo_ff, mid_ff, hi_ff);

   always_ff @(posedge clock) begin
      if (en.med) begin
         med_ff <= med_in;
      end
   end

   assign med_out = med_ff;

endmodule
